@@ src/sha1s_pkg.sv @@
// sha-1 stream hasher package: constants, types and the round function helpers
`timescale 1ns / 1ps

package sha1s_pkg;

    localparam int WORD_W   = 32;
    localparam int HASH_N   = 5;
    localparam int WIN_N    = 16;
    localparam int ROUND_W  = 7;
    localparam int FILL_W   = 6;
    localparam int IDX_W    = 3;

    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

    localparam logic [WORD_W-1:0] H0_INIT = 32'h67452301;
    localparam logic [WORD_W-1:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [WORD_W-1:0] H2_INIT = 32'h98BADCFE;
    localparam logic [WORD_W-1:0] H3_INIT = 32'h10325476;
    localparam logic [WORD_W-1:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [WORD_W-1:0] K_CH  = 32'h5A827999;
    localparam logic [WORD_W-1:0] K_P1  = 32'h6ED9EBA1;
    localparam logic [WORD_W-1:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [WORD_W-1:0] K_P2  = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // round variables a..e
    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
        logic [WORD_W-1:0] e;
    } t_work;

    // round control handed to the round unit
    typedef struct packed {
        logic [ROUND_W-1:0] round;
        logic [WORD_W-1:0]  w;
    } t_round_ctl;

    function automatic logic [WORD_W-1:0] init_word(input logic [IDX_W-1:0] idx);
        logic [WORD_W-1:0] v;
        case (idx)
            3'd0:    v = H0_INIT;
            3'd1:    v = H1_INIT;
            3'd2:    v = H2_INIT;
            3'd3:    v = H3_INIT;
            default: v = H4_INIT;
        endcase
        return v;
    endfunction

endpackage

@@ src/sha1s_round.sv @@
// one sha-1 round: f and k selection, five-term add, word rotation
`timescale 1ns / 1ps

module sha1s_round (
    input  sha1s_pkg::t_work      i_work,
    input  sha1s_pkg::t_round_ctl i_ctl,
    output sha1s_pkg::t_work      o_work
);

    logic [31:0] f;
    logic [31:0] k;
    logic [31:0] t;

    always_comb begin
        if (i_ctl.round < 7'd20) begin
            f = (i_work.b & i_work.c) | (~i_work.b & i_work.d);
            k = sha1s_pkg::K_CH;
        end else if (i_ctl.round < 7'd40) begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = sha1s_pkg::K_P1;
        end else if (i_ctl.round < 7'd60) begin
            f = (i_work.b & i_work.c) | (i_work.b & i_work.d) | (i_work.c & i_work.d);
            k = sha1s_pkg::K_MAJ;
        end else begin
            f = i_work.b ^ i_work.c ^ i_work.d;
            k = sha1s_pkg::K_P2;
        end
    end

    assign t = {i_work.a[26:0], i_work.a[31:27]} + f + i_work.e + k + i_ctl.w;

    always_comb begin
        o_work.a = t;
        o_work.b = i_work.a;
        o_work.c = {i_work.b[1:0], i_work.b[31:2]};
        o_work.d = i_work.c;
        o_work.e = i_work.d;
    end

endmodule

@@ src/sha1_stream_hasher.sv @@
// sha-1 stream hasher top level: byte collection, padding, round sequencer, digest output
`timescale 1ns / 1ps

// Takes a message one byte per beat and returns its SHA-1 digest as five beats,
// H0 first, the last one flagged by tlast. A byte beat is taken every cycle while
// a 64-byte block fills; the 64th byte starts a compression that holds tready low
// through 80 rounds in the single shared round unit, one per cycle, and then the
// chaining add. The end-of-message beat starts padding, which inserts one pad
// byte per cycle up to the end of the block, going on into a second block when
// the length field does not fit, with one or two compressions, after which the five
// digest beats are offered; the block accepts the next message once the fifth
// beat is taken.
module sha1_stream_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // data_byte
    input  logic        i_s_tuser,   // byte_present
    input  logic        i_s_tlast,   // end_of_message
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // digest_word[31:0], word_index[34:32], zero fill
    output logic        o_m_tlast    // last_word
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FIN  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_state, n_state;
    logic [2:0]  r_ret, n_ret;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic        r_pad80, n_pad80;
    logic        r_wrap, n_wrap;
    logic [6:0]  r_round, n_round;
    logic [23:0] r_acc, n_acc;
    logic [2:0]  r_idx, n_idx;
    logic [31:0] r_win [16];
    logic [31:0] n_win [16];
    logic [31:0] r_h [5];
    logic [31:0] n_h [5];
    sha1s_pkg::t_work      r_work, n_work;
    sha1s_pkg::t_work      round_out;
    sha1s_pkg::t_round_ctl round_ctl;

    logic        s_acc;
    logic        m_acc;
    logic        app_en;
    logic [7:0]  app_byte;
    logic        full;
    logic [31:0] sched_w;
    sha1s_pkg::t_work h_work;

    assign s_acc = i_s_tvalid & o_s_tready;
    assign m_acc = o_m_tvalid & i_m_tready;
    assign full  = (r_fill == 6'd63);

    assign sched_w = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];

    assign round_ctl.round = r_round;
    assign round_ctl.w     = r_win[0];

    assign h_work = '{a: r_h[0], b: r_h[1], c: r_h[2], d: r_h[3], e: r_h[4]};

    sha1s_round u_round (
        .i_work (r_work),
        .i_ctl  (round_ctl),
        .o_work (round_out)
    );

    // byte source for the block assembler
    always_comb begin
        app_en   = 1'b0;
        app_byte = 8'h00;
        if (r_state == ST_IDLE) begin
            app_en   = s_acc & i_s_tuser;
            app_byte = i_s_tdata;
        end else if (r_state == ST_PAD) begin
            app_en = 1'b1;
            if (r_pad80) begin
                app_byte = sha1s_pkg::PAD_BYTE;
            end else if (!r_wrap && r_fill >= 6'd56) begin
                app_byte = r_bits[63:56];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_fill  = r_fill;
        n_bits  = r_bits;
        n_pad80 = r_pad80;
        n_wrap  = r_wrap;
        n_round = r_round;
        n_acc   = r_acc;
        n_idx   = r_idx;
        n_work  = r_work;
        for (int i = 0; i < 16; i++) begin
            n_win[i] = r_win[i];
        end
        for (int i = 0; i < 5; i++) begin
            n_h[i] = r_h[i];
        end

        if (app_en) begin
            n_acc  = {r_acc[15:0], app_byte};
            n_fill = r_fill + 6'd1;
            if (r_fill[1:0] == 2'b11) begin
                for (int i = 0; i < 15; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[15] = {r_acc, app_byte};
            end
        end

        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (i_s_tuser) begin
                        n_bits = r_bits + 64'd8;
                    end
                    if (i_s_tlast) begin
                        n_pad80 = 1'b1;
                    end
                    if (i_s_tuser && full) begin
                        n_state = ST_COMP;
                        n_ret   = i_s_tlast ? ST_PAD : ST_IDLE;
                        n_work  = h_work;
                        n_round = '0;
                    end else if (i_s_tlast) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                n_pad80 = 1'b0;
                if (!r_pad80 && !r_wrap && r_fill >= 6'd56) begin
                    n_bits = {r_bits[55:0], 8'h00};
                end
                // pad byte past the length slot: zeros to the end, then a second block
                if (r_pad80 && r_fill >= 6'd56) begin
                    n_wrap = 1'b1;
                end
                if (full) begin
                    n_wrap  = 1'b0;
                    n_state = ST_COMP;
                    n_ret   = (!r_pad80 && !r_wrap) ? ST_OUT : ST_PAD;
                    n_work  = h_work;
                    n_round = '0;
                end
            end
            ST_COMP: begin
                n_work = round_out;
                for (int i = 0; i < 15; i++) begin
                    n_win[i] = r_win[i+1];
                end
                n_win[15] = {sched_w[30:0], sched_w[31]};
                if (r_round == sha1s_pkg::ROUND_LAST) begin
                    n_round = '0;
                    n_state = ST_FIN;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            ST_FIN: begin
                n_h[0]  = r_h[0] + r_work.a;
                n_h[1]  = r_h[1] + r_work.b;
                n_h[2]  = r_h[2] + r_work.c;
                n_h[3]  = r_h[3] + r_work.d;
                n_h[4]  = r_h[4] + r_work.e;
                n_state = r_ret;
            end
            ST_OUT: begin
                if (m_acc) begin
                    if (r_idx == 3'd4) begin
                        n_idx   = '0;
                        n_state = ST_IDLE;
                        n_bits  = '0;
                        n_fill  = '0;
                        for (int i = 0; i < 5; i++) begin
                            n_h[i] = sha1s_pkg::init_word(3'(i));
                        end
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ret   <= ST_IDLE;
            r_fill  <= '0;
            r_bits  <= '0;
            r_pad80 <= 1'b0;
            r_wrap  <= 1'b0;
            r_round <= '0;
            r_idx   <= '0;
            r_work  <= '0;
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= sha1s_pkg::init_word(3'(i));
            end
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_fill  <= n_fill;
            r_bits  <= n_bits;
            r_pad80 <= n_pad80;
            r_wrap  <= n_wrap;
            r_round <= n_round;
            r_idx   <= n_idx;
            r_work  <= n_work;
            for (int i = 0; i < 5; i++) begin
                r_h[i] <= n_h[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        for (int i = 0; i < 16; i++) begin
            r_win[i] <= n_win[i];
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = (r_state == ST_OUT);
    assign o_m_tdata  = {5'd0, r_idx, r_h[r_idx]};
    assign o_m_tlast  = (r_idx == 3'd4);

    // a compression always starts and ends on a block boundary
    a_fin_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |-> (r_fill == 6'd0))
        else $error("fill count not at block boundary after compression");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMP) |-> (r_round <= sha1s_pkg::ROUND_LAST))
        else $error("round counter out of range");

    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input taken while digest pending");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && o_m_tlast) |=> (r_h[0] == sha1s_pkg::H0_INIT && r_bits == 64'd0))
        else $error("state not reloaded after digest");

    a_wrap_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wrap |-> (r_state == ST_PAD))
        else $error("second-block flag outside padding");

endmodule
